// ===== design/ntb_pkg.sv =====
package ntb_pkg;

    // residue width and modulus
    localparam int DataW = 14;
    localparam logic [DataW-1:0] ModQ = 14'd12289;

    // montgomery radix R = 2^RBits and -q^-1 mod R
    localparam int RBits = 16;
    localparam logic [RBits-1:0] QNegInv = 16'd12287;

    // reset value of the scale register
    localparam logic [DataW-1:0] ScaleReset = 14'd64;

    // montgomery datapath widths and latency
    localparam int ProdW = 2 * DataW;
    localparam int MulW = RBits + DataW;
    localparam int SumW = MulW + 1;
    localparam int MontLat = 4;

    typedef enum logic [1:0] {
        CMD_FWD   = 2'd0,
        CMD_INV   = 2'd1,
        CMD_SCALE = 2'd2
    } cmd_t;

    // fields that travel beside the multiplier
    typedef struct packed {
        cmd_t             cmd;
        logic [DataW-1:0] a;
        logic [DataW-1:0] sum;
        logic             err;
    } side_t;

    // (a + b) mod q
    function automatic logic [DataW-1:0] mod_add(input logic [DataW-1:0] a,
                                                 input logic [DataW-1:0] b);
        logic [DataW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, ModQ})
        begin
            s = s - {1'b0, ModQ};
        end
        return s[DataW-1:0];
    endfunction

    // (a - b) mod q
    function automatic logic [DataW-1:0] mod_sub(input logic [DataW-1:0] a,
                                                 input logic [DataW-1:0] b);
        logic [DataW:0] s;
        if (a >= b)
        begin
            s = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            s = {1'b0, a} + {1'b0, ModQ} - {1'b0, b};
        end
        return s[DataW-1:0];
    endfunction

endpackage

// ===== design/ntb_in_if.sv =====
interface ntb_in_if;
    import ntb_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       command;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
    logic [DataW-1:0] twiddle;

    modport source (
        output valid,
        output command,
        output operand_a,
        output operand_b,
        output twiddle,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  operand_a,
        input  operand_b,
        input  twiddle,
        output ready
    );

endinterface

// ===== design/ntb_out_if.sv =====
interface ntb_out_if;
    import ntb_pkg::*;

    logic             valid;
    logic             ready;
    logic [DataW-1:0] result_a;
    logic [DataW-1:0] result_b;
    logic             range_error;

    modport source (
        output valid,
        output result_a,
        output result_b,
        output range_error,
        input  ready
    );

    modport sink (
        input  valid,
        input  result_a,
        input  result_b,
        input  range_error,
        output ready
    );

endinterface

// ===== design/ntb_mont.sv =====
module ntb_mont (
    input  logic                     clk,
    input  logic                     en,
    input  logic [ntb_pkg::DataW-1:0] x,
    input  logic [ntb_pkg::DataW-1:0] y,
    output logic [ntb_pkg::DataW-1:0] r
);
    import ntb_pkg::*;

    logic [ProdW-1:0]   t1_reg;
    logic [ProdW-1:0]   t2_reg;
    logic [ProdW-1:0]   t3_reg;
    logic [RBits-1:0]   mlo_reg;
    logic [MulW-1:0]    m_reg;
    logic [DataW-1:0]   r_reg;

    logic [ProdW-1:0]   t1_next;
    logic [2*RBits-1:0] mlo_full;
    logic [RBits-1:0]   mlo_next;
    logic [MulW-1:0]    m_next;
    logic [SumW-1:0]    sum_full;
    logic [DataW:0]     red;
    logic [DataW-1:0]   r_next;

    // product x*y
    assign t1_next = ProdW'(x) * ProdW'(y);

    // m = (t * -q^-1) mod R
    assign mlo_full = (2*RBits)'(t1_reg[RBits-1:0]) * (2*RBits)'(QNegInv);
    assign mlo_next = mlo_full[RBits-1:0];

    // m * q
    assign m_next = MulW'(mlo_reg) * MulW'(ModQ);

    // (t + m*q) / R, then one conditional subtract
    assign sum_full = SumW'(t3_reg) + SumW'(m_reg);
    assign red      = sum_full[SumW-1:RBits];
    assign r_next   = (red >= {1'b0, ModQ}) ? DataW'(red - {1'b0, ModQ}) : red[DataW-1:0];

    // four pipeline stages, frozen together on a stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg  <= t1_next;
            mlo_reg <= mlo_next;
            t2_reg  <= t1_reg;
            m_reg   <= m_next;
            t3_reg  <= t2_reg;
            r_reg   <= r_next;
        end
    end

    assign r = r_reg;

endmodule

// ===== design/ntt_butterfly_montgomery.sv =====
// NTT butterfly over q = 12289 with Montgomery multiplication (R = 2^16).
// One transaction is accepted every cycle unless the output is stalled; each
// gives one result through the input register, operand select, four-stage
// Montgomery multiplier and output register. When the output is stalled the whole
// pipeline holds, so the sustained rate is one transaction per cycle as
// long as results are taken. scale_factor may only be written while the
// pipeline is empty.
module ntt_butterfly_montgomery (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      scale_factor_we,
    input  logic [ntb_pkg::DataW-1:0] scale_factor_wdata,
    ntb_in_if.sink                    din,
    ntb_out_if.source                 dout
);
    import ntb_pkg::*;

    logic             adv;
    logic [DataW-1:0] scale_factor_reg;

    // stage 1: input register
    logic             s1_valid_reg;
    cmd_t             s1_cmd_reg;
    logic [DataW-1:0] s1_a_reg;
    logic [DataW-1:0] s1_b_reg;
    logic [DataW-1:0] s1_tw_reg;

    // stage 2: multiplier operands
    logic             s2_valid_reg;
    logic [DataW-1:0] s2_x_reg;
    logic [DataW-1:0] s2_y_reg;
    side_t            s2_side_reg;
    logic [DataW-1:0] s2_x_next;
    logic [DataW-1:0] s2_y_next;
    side_t            s2_side_next;

    // side pipeline beside the multiplier
    logic             mv_reg [MontLat];
    side_t            side_reg [MontLat];
    logic [DataW-1:0] mont_r;

    // output stage
    logic             out_valid_reg;
    logic [DataW-1:0] result_a_reg;
    logic [DataW-1:0] result_b_reg;
    logic             err_reg;
    cmd_t             out_cmd_reg;
    logic [DataW-1:0] result_a_next;
    logic [DataW-1:0] result_b_next;
    logic             err_next;
    side_t            last;

    // whole pipeline moves when the output register is free or being taken
    assign adv       = !out_valid_reg || dout.ready;
    assign din.ready = adv;

    // scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_factor_reg <= ScaleReset;
        end
        else if (scale_factor_we)
        begin
            scale_factor_reg <= scale_factor_wdata;
        end
    end

    // range check and operand select
    always_comb
    begin
        s2_side_next.cmd = s1_cmd_reg;
        s2_side_next.a   = s1_a_reg;
        s2_side_next.sum = mod_add(s1_a_reg, s1_b_reg);
        s2_side_next.err = 1'b0;
        s2_x_next        = s1_b_reg;
        s2_y_next        = s1_tw_reg;
        if (s1_cmd_reg inside {CMD_FWD, CMD_INV})
        begin
            s2_side_next.err = (s1_a_reg >= ModQ) || (s1_b_reg >= ModQ) ||
                               (s1_tw_reg >= ModQ);
        end
        case (s1_cmd_reg)
            CMD_FWD:
            begin
                s2_x_next = s1_b_reg;
                s2_y_next = s1_tw_reg;
            end
            CMD_INV:
            begin
                s2_x_next = mod_sub(s1_a_reg, s1_b_reg);
                s2_y_next = s1_tw_reg;
            end
            CMD_SCALE:
            begin
                s2_x_next        = s1_a_reg;
                s2_y_next        = scale_factor_reg;
                s2_side_next.err = (s1_a_reg >= ModQ) || (scale_factor_reg >= ModQ);
            end
            default:
            begin
                s2_x_next = '0;
                s2_y_next = '0;
            end
        endcase
    end

    // montgomery multiplier
    ntb_mont u_mont (
        .clk (clk),
        .en  (adv),
        .x   (s2_x_reg),
        .y   (s2_y_reg),
        .r   (mont_r)
    );

    // final add/sub and result select
    assign last = side_reg[MontLat-1];

    always_comb
    begin
        result_a_next = '0;
        result_b_next = '0;
        err_next      = last.err;
        if (!last.err)
        begin
            case (last.cmd)
                CMD_FWD:
                begin
                    result_a_next = mod_add(last.a, mont_r);
                    result_b_next = mod_sub(last.a, mont_r);
                end
                CMD_INV:
                begin
                    result_a_next = last.sum;
                    result_b_next = mont_r;
                end
                CMD_SCALE:
                begin
                    result_a_next = mont_r;
                end
                default:
                begin
                    result_a_next = '0;
                end
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MontLat; i++)
            begin
                mv_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg  <= din.valid;
            s2_valid_reg  <= s1_valid_reg;
            mv_reg[0]     <= s2_valid_reg;
            for (int i = 1; i < MontLat; i++)
            begin
                mv_reg[i] <= mv_reg[i-1];
            end
            out_valid_reg <= mv_reg[MontLat-1];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg   <= cmd_t'(din.command);
            s1_a_reg     <= din.operand_a;
            s1_b_reg     <= din.operand_b;
            s1_tw_reg    <= din.twiddle;
            s2_x_reg     <= s2_x_next;
            s2_y_reg     <= s2_y_next;
            s2_side_reg  <= s2_side_next;
            side_reg[0]  <= s2_side_reg;
            for (int i = 1; i < MontLat; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            result_a_reg <= result_a_next;
            result_b_reg <= result_b_next;
            err_reg      <= err_next;
            out_cmd_reg  <= last.cmd;
        end
    end

    assign dout.valid       = out_valid_reg;
    assign dout.result_a    = result_a_reg;
    assign dout.result_b    = result_b_reg;
    assign dout.range_error = err_reg;

    // results of an in-range transaction are reduced residues
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !err_reg |-> (result_a_reg < ModQ) && (result_b_reg < ModQ))
        else $error("result not reduced mod q");

    // a flagged transaction carries zero results
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && err_reg |-> (result_a_reg == '0) && (result_b_reg == '0))
        else $error("range error with nonzero result");

    // scaling leaves the second result at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_cmd_reg == CMD_SCALE) |-> (result_b_reg == '0))
        else $error("scale result_b not zero");

    // a stall freezes the tail of the multiplier pipe
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(mv_reg[MontLat-1]) && $stable(mont_r))
        else $error("multiplier pipe moved during stall");

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ntb_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [DataW-1:0] FieldMax = '1;
    localparam int DrainCycles = 12;
    localparam int HoldCycles = 300;
    localparam int CycleLimit = 200000;
    localparam int NumDirected = 22;

    typedef struct packed {
        logic [DataW-1:0] res_a;
        logic [DataW-1:0] res_b;
        logic             err;
    } bfly_res_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic [DataW-1:0] tw;
        logic             typed;
        bfly_res_t        want;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             scale_factor_we;
    logic [DataW-1:0] scale_factor_wdata;

    ntb_in_if  din ();
    ntb_out_if dout ();

    ntt_butterfly_montgomery u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .scale_factor_we    (scale_factor_we),
        .scale_factor_wdata (scale_factor_wdata),
        .din                (din.sink),
        .dout               (dout.source)
    );

    // copy of the scale register and the results still owed by the block
    logic [DataW-1:0] scale_shadow;
    bfly_res_t        butterfly_q[$];
    int               err_count = 0;
    int               cycle_count = 0;
    int               send_idle_pct = 21;
    int               recv_idle_pct = 74;
    logic             pressure_go = 1'b0;
    logic             hold_off = 1'b0;

    // directed rows: edges of each field, every command, range errors
    stim_row_t directed_rows [0:NumDirected-1] = '{
        '{CMD_FWD,    0,        0,        0,        1'b1, '{0, 0, 1'b0}},
        '{CMD_FWD,    ModQ-1,   ModQ-1,   ModQ-1,   1'b0, '{0, 0, 1'b0}},
        '{CMD_FWD,    1,        1,        1,        1'b0, '{0, 0, 1'b0}},
        '{CMD_FWD,    0,        5000,     7000,     1'b0, '{0, 0, 1'b0}},
        '{CMD_FWD,    ModQ,     0,        0,        1'b1, '{0, 0, 1'b1}},
        '{CMD_FWD,    0,        ModQ,     0,        1'b1, '{0, 0, 1'b1}},
        '{CMD_FWD,    0,        0,        ModQ,     1'b1, '{0, 0, 1'b1}},
        '{CMD_FWD,    FieldMax, FieldMax, FieldMax, 1'b1, '{0, 0, 1'b1}},
        '{CMD_INV,    0,        0,        0,        1'b1, '{0, 0, 1'b0}},
        '{CMD_INV,    ModQ-1,   ModQ-1,   ModQ-1,   1'b1, '{ModQ-2, 0, 1'b0}},
        '{CMD_INV,    1,        ModQ-1,   1,        1'b0, '{0, 0, 1'b0}},
        '{CMD_INV,    0,        ModQ-1,   ModQ-1,   1'b0, '{0, 0, 1'b0}},
        '{CMD_INV,    ModQ,     0,        0,        1'b1, '{0, 0, 1'b1}},
        '{CMD_INV,    0,        FieldMax, 0,        1'b1, '{0, 0, 1'b1}},
        '{CMD_INV,    0,        0,        FieldMax, 1'b1, '{0, 0, 1'b1}},
        '{CMD_SCALE,  0,        0,        0,        1'b1, '{0, 0, 1'b0}},
        '{CMD_SCALE,  ModQ-1,   0,        0,        1'b0, '{0, 0, 1'b0}},
        '{CMD_SCALE,  5,        FieldMax, FieldMax, 1'b0, '{0, 0, 1'b0}},
        '{CMD_SCALE,  ModQ,     0,        0,        1'b1, '{0, 0, 1'b1}},
        '{CMD_SCALE,  FieldMax, 0,        0,        1'b1, '{0, 0, 1'b1}},
        '{CMD_UNUSED, FieldMax, FieldMax, FieldMax, 1'b1, '{0, 0, 1'b0}},
        '{CMD_UNUSED, 1,        2,        3,        1'b1, '{0, 0, 1'b0}}
    };

    // x * y * 2^-16 mod q
    function automatic logic [DataW-1:0] mont_product(input logic [DataW-1:0] x,
                                                      input logic [DataW-1:0] y);
        logic [31:0] t;
        logic [31:0] m;
        logic [31:0] r;
        t = 32'(x) * 32'(y);
        m = ((32'(t[15:0]) * 32'(QNegInv)) & 32'h0000_FFFF) * 32'(ModQ);
        r = (t + m) >> RBits;
        if (r >= 32'(ModQ))
        begin
            r = r - 32'(ModQ);
        end
        return r[DataW-1:0];
    endfunction

    function automatic logic [DataW-1:0] add_modq(input logic [DataW-1:0] x,
                                                  input logic [DataW-1:0] y);
        logic [DataW:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, ModQ})
        begin
            s = s - {1'b0, ModQ};
        end
        return s[DataW-1:0];
    endfunction

    function automatic logic [DataW-1:0] sub_modq(input logic [DataW-1:0] x,
                                                  input logic [DataW-1:0] y);
        logic [DataW:0] s;
        if (x >= y)
        begin
            s = {1'b0, x} - {1'b0, y};
        end
        else
        begin
            s = {1'b0, x} + {1'b0, ModQ} - {1'b0, y};
        end
        return s[DataW-1:0];
    endfunction

    // expected butterfly outputs for one transaction
    function automatic bfly_res_t predict_butterfly(input logic [1:0]       cmd,
                                                    input logic [DataW-1:0] a,
                                                    input logic [DataW-1:0] b,
                                                    input logic [DataW-1:0] tw,
                                                    input logic [DataW-1:0] scale);
        bfly_res_t        res;
        logic [DataW-1:0] v;
        res = '0;
        case (cmd)
            CMD_FWD, CMD_INV:
            begin
                if (a >= ModQ || b >= ModQ || tw >= ModQ)
                begin
                    res.err = 1'b1;
                end
                else if (cmd == CMD_FWD)
                begin
                    v = mont_product(b, tw);
                    res.res_a = add_modq(a, v);
                    res.res_b = sub_modq(a, v);
                end
                else
                begin
                    res.res_a = add_modq(a, b);
                    res.res_b = mont_product(sub_modq(a, b), tw);
                end
            end
            CMD_SCALE:
            begin
                if (a >= ModQ || scale >= ModQ)
                begin
                    res.err = 1'b1;
                end
                else
                begin
                    res.res_a = mont_product(a, scale);
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // offer one transaction, wait for it to be taken, record what it owes
    task automatic send_butterfly(input logic [1:0]       cmd,
                                  input logic [DataW-1:0] a,
                                  input logic [DataW-1:0] b,
                                  input logic [DataW-1:0] tw,
                                  input logic             typed,
                                  input bfly_res_t        want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            din.valid <= 1'b0;
            @(posedge clk);
        end
        din.valid     <= 1'b1;
        din.command   <= cmd;
        din.operand_a <= a;
        din.operand_b <= b;
        din.twiddle   <= tw;
        do
        begin
            @(posedge clk);
        end
        while (!din.ready);
        if (typed)
        begin
            butterfly_q.push_back(want);
        end
        else
        begin
            butterfly_q.push_back(predict_butterfly(cmd, a, b, tw, scale_shadow));
        end
    endtask

    // mostly in-range residues, some operands pushed past q or over the full field
    task automatic send_random(input int count);
        logic [1:0]       cmd;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic [DataW-1:0] tw;
        int               pick;
        repeat (count)
        begin
            pick = $urandom_range(19);
            cmd = (pick < 8) ? CMD_FWD : (pick < 15) ? CMD_INV :
                  (pick < 19) ? CMD_SCALE : CMD_UNUSED;
            a  = DataW'($urandom_range(ModQ - 1));
            b  = DataW'($urandom_range(ModQ - 1));
            tw = DataW'($urandom_range(ModQ - 1));
            case ($urandom_range(15))
                0: a  = DataW'($urandom_range(FieldMax, ModQ));
                1: b  = DataW'($urandom_range(FieldMax, ModQ));
                2: tw = DataW'($urandom_range(FieldMax, ModQ));
                3:
                begin
                    a  = DataW'($urandom_range(FieldMax));
                    b  = DataW'($urandom_range(FieldMax));
                    tw = DataW'($urandom_range(FieldMax));
                end
                default:
                begin
                end
            endcase
            send_butterfly(cmd, a, b, tw, 1'b0, '0);
        end
    endtask

    // write the scale register once the pipeline has emptied
    task automatic write_scale(input logic [DataW-1:0] value);
        din.valid <= 1'b0;
        while (butterfly_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
        scale_factor_we    <= 1'b1;
        scale_factor_wdata <= value;
        @(posedge clk);
        scale_factor_we <= 1'b0;
        scale_shadow = value;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // long output stall while the sender keeps offering
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_off <= 1'b0;
    end

    // result side: check each transaction, then pick the next ready
    always @(posedge clk)
    begin : result_check
        bfly_res_t want;
        if (rst_n && dout.valid && dout.ready)
        begin
            if (butterfly_q.size() == 0)
            begin
                report_mismatch("unexpected result_a", int'(dout.result_a), 0);
            end
            else
            begin
                want = butterfly_q.pop_front();
                if (dout.result_a !== want.res_a)
                begin
                    report_mismatch("result_a", int'(dout.result_a), int'(want.res_a));
                end
                if (dout.result_b !== want.res_b)
                begin
                    report_mismatch("result_b", int'(dout.result_b), int'(want.res_b));
                end
                if (dout.range_error !== want.err)
                begin
                    report_mismatch("range_error", int'(dout.range_error), int'(want.err));
                end
            end
        end
        dout.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // main sequence
    initial
    begin
        rst_n              = 1'b0;
        scale_factor_we    = 1'b0;
        scale_factor_wdata = '0;
        din.valid          = 1'b0;
        din.command        = CMD_FWD;
        din.operand_a      = '0;
        din.operand_b      = '0;
        din.twiddle        = '0;
        scale_shadow       = ScaleReset;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under the reset scale value
        for (int i = 0; i < NumDirected; i++)
        begin
            send_butterfly(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b,
                           directed_rows[i].tw, directed_rows[i].typed,
                           directed_rows[i].want);
        end

        write_scale('0);
        send_random(100);

        send_idle_pct <= 74;
        recv_idle_pct <= 21;
        write_scale(ModQ - 1);
        send_random(150);

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        write_scale(DataW'($urandom_range(ModQ - 1)));
        send_random(150);

        // back-pressure until the input stalls
        write_scale(1);
        pressure_go <= 1'b1;
        send_random(60);

        // scale register out of range
        write_scale(ModQ);
        send_random(40);
        write_scale(FieldMax);
        send_random(40);

        write_scale(DataW'($urandom_range(ModQ - 1)));
        send_random(160);

        din.valid <= 1'b0;
        while (butterfly_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
        if (err_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
